// ===== hdl/bal_pkg.sv =====
// shared constants, request codes and controller/datapath interface types
package bal_pkg;

  localparam int CAPACITY_DEF = 8;
  localparam int VALUE_W      = 32;
  localparam int KIND_W       = 2;
  localparam int COUNT_W      = 4;

  localparam logic [KIND_W-1:0] KIND_INSERT      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE_HEAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE_TAIL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SWAP        = 2'd3;

  typedef struct packed {
    logic start;
    logic shift_en;
    logic scan_en;
    logic wr_a;
    logic wr_b;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic found_both;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/bal_dp.sv =====
// list datapath: entry memory, count, walk index, search results and output register
module bal_dp #(
  parameter int CAPACITY = bal_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bal_pkg::cmd_t                     cmd_i,
  output bal_pkg::sts_t                     sts_o,
  input  logic        [bal_pkg::KIND_W-1:0] kind_i,
  input  logic signed [bal_pkg::VALUE_W-1:0] value_i,
  input  logic signed [bal_pkg::VALUE_W-1:0] second_value_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic                              out_ok_o,
  output logic        [bal_pkg::COUNT_W-1:0] out_entry_count_o
);
  import bal_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  logic [VALUE_W-1:0] mem_q [CAPACITY];
  logic [VALUE_W-1:0] rdata_q;
  logic [VALUE_W-1:0] val_a_q, val_b_q;
  logic [KIND_W-1:0]  kind_q;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      rd_idx_q;
  logic [CW-1:0]      rd_prev;
  logic [AW-1:0]      pos_a_q, pos_b_q;
  logic               rd_pend_q;
  logic               have_a_q, have_b_q;
  logic               ok_q;
  logic               out_valid_q;
  logic               out_ok_q;
  logic [COUNT_W-1:0] out_cnt_q;
  logic [EW-1:0]      cnt_ext;
  logic               issue;
  logic               full;
  logic               empty;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data;

  assign full    = (cnt_q >= CAP_C);
  assign empty   = (cnt_q == '0);
  assign issue   = (cmd_i.shift_en && (idx_q <= cnt_q)) || (cmd_i.scan_en && (idx_q < cnt_q));
  assign rd_prev = rd_idx_q - ONE_C;
  assign cnt_ext = EW'(cnt_q);

  assign sts_o.walk_done  = !issue && !rd_pend_q;
  assign sts_o.found_both = have_a_q && have_b_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_q[AW-1:0];
    wr_data = value_i;
    priority if (cmd_i.start && (kind_i == KIND_INSERT) && !full) begin
      wr_en = 1'b1;
    end else if (rd_pend_q && (kind_q == KIND_REMOVE_HEAD)) begin
      wr_en   = 1'b1;
      wr_addr = rd_prev[AW-1:0];
      wr_data = rdata_q;
    end else if (cmd_i.wr_a) begin
      wr_en   = 1'b1;
      wr_addr = pos_a_q;
      wr_data = val_b_q;
    end else if (cmd_i.wr_b) begin
      wr_en   = 1'b1;
      wr_addr = pos_b_q;
      wr_data = val_a_q;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (cmd_i.start) begin
      unique case (kind_i)
        KIND_INSERT: begin
          if (!full) cnt_d = cnt_q + ONE_C;
        end
        KIND_REMOVE_HEAD: begin
          if (!empty) cnt_d = cnt_q - ONE_C;
          idx_d = ONE_C;
        end
        KIND_REMOVE_TAIL: begin
          if (!empty) cnt_d = cnt_q - ONE_C;
        end
        default: begin
          idx_d = '0;
        end
      endcase
    end else if (issue) begin
      idx_d = idx_q + ONE_C;
    end
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (issue) begin
      rdata_q  <= mem_q[idx_q[AW-1:0]];
      rd_idx_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      have_a_q    <= 1'b0;
      have_b_q    <= 1'b0;
      ok_q        <= 1'b0;
      kind_q      <= KIND_INSERT;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      rd_pend_q <= issue;
      if (cmd_i.start) begin
        kind_q   <= kind_i;
        have_a_q <= 1'b0;
        have_b_q <= 1'b0;
        ok_q     <= (kind_i == KIND_INSERT) ? !full : !empty;
      end else if (rd_pend_q && (kind_q == KIND_SWAP)) begin
        priority if (rdata_q == val_a_q) begin
          have_a_q <= 1'b1;
        end else if (rdata_q == val_b_q) begin
          have_b_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      val_a_q <= value_i;
      val_b_q <= second_value_i;
    end
    if (rd_pend_q && (kind_q == KIND_SWAP)) begin
      priority if (rdata_q == val_a_q) begin
        pos_a_q <= rd_idx_q[AW-1:0];
      end else if (rdata_q == val_b_q) begin
        pos_b_q <= rd_idx_q[AW-1:0];
      end
    end
    if (cmd_i.finish) begin
      out_ok_q  <= (kind_q == KIND_SWAP) ? (have_a_q && have_b_q) : ok_q;
      out_cnt_q <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_ok_o          = out_ok_q;
  assign out_entry_count_o = out_cnt_q;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CAP_C)
    else $error("entry count above capacity");

  a_finish_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> sts_o.out_free)
    else $error("result loaded over an unsent result");

  a_swap_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_b |-> $past(cmd_i.wr_a) && have_a_q && have_b_q)
    else $error("swap write without both positions found");

  a_insert_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start && (kind_i == KIND_INSERT) && !full |=> cnt_q == $past(cnt_q) + ONE_C)
    else $error("insert did not advance the count");

endmodule

// ===== hdl/bal_ctrl.sv =====
// request sequencer: accepts a transaction, walks the list and releases the result
module bal_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bal_pkg::KIND_W-1:0]   in_kind_i,
  input  bal_pkg::sts_t                sts_i,
  output bal_pkg::cmd_t                cmd_o
);
  import bal_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SHIFT  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SWAP_A = 3'd3;
  localparam logic [2:0] S_SWAP_B = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.shift_en = (state_q == S_SHIFT);
    cmd_o.scan_en  = (state_q == S_SCAN);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          unique case (in_kind_i)
            KIND_REMOVE_HEAD: state_d = S_SHIFT;
            KIND_SWAP:        state_d = S_SCAN;
            default:          state_d = S_DONE;
          endcase
        end
      end
      S_SHIFT: begin
        if (sts_i.walk_done) state_d = S_DONE;
      end
      S_SCAN: begin
        if (sts_i.walk_done) state_d = sts_i.found_both ? S_SWAP_A : S_DONE;
      end
      S_SWAP_A: begin
        cmd_o.wr_a = 1'b1;
        state_d    = S_SWAP_B;
      end
      S_SWAP_B: begin
        cmd_o.wr_b = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q != S_IDLE))
    else $error("accepted transaction left the sequencer idle");

  a_swap_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWAP_A) |=> (state_q == S_SWAP_B))
    else $error("swap write sequence broken");

  a_done_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && !sts_i.out_free |=> (state_q == S_DONE))
    else $error("result dropped while output busy");

endmodule

// ===== hdl/bounded_array_list_engine.sv =====
// bounded ordered list engine: insert, remove head, remove tail and swap on signed words
// insert and remove tail: no walk; the result is registered once the done state finds the output register free
// remove head: each later entry moves down one place, one entry moved per cycle through the memory port
// swap: a search over all entries, then the two found positions are written in turn when both are found
// one transaction at a time; the result waits in an output register while stalled
// reset empties the list and clears the control state; entry words are not reset
module bounded_array_list_engine #(
  parameter int CAPACITY = bal_pkg::CAPACITY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic        [bal_pkg::KIND_W-1:0]  in_kind_i,
  input  logic signed [bal_pkg::VALUE_W-1:0] in_value_i,
  input  logic signed [bal_pkg::VALUE_W-1:0] in_second_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               out_ok_o,
  output logic        [bal_pkg::COUNT_W-1:0] out_entry_count_o
);
  import bal_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_kind_i  (in_kind_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bal_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .kind_i            (in_kind_i),
    .value_i           (in_value_i),
    .second_value_i    (in_second_value_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .out_ok_o          (out_ok_o),
    .out_entry_count_o (out_entry_count_o)
  );

endmodule
